FILE: hw/rtl/pbs_pkg.sv
// ----------------------------------------------------------------------------
// pbs_pkg
// Shared widths, constants and the line event type of the projection band
// segmentation block.
// ----------------------------------------------------------------------------
`default_nettype none

package pbs_pkg;

   localparam int LINE_W          = 12;
   localparam int BUDGET_W        = 8;
   localparam int MAX_LINES_DEF   = 4096;
   localparam int QUEUE_DEPTH     = 2;
   localparam int LINE_IDX_MAX    = 4095;

   localparam logic [BUDGET_W-1:0] GAP_BUDGET_RESET = 8'd16;

   // one finished line as seen by the front end
   typedef struct packed {
      logic filled;
      logic image_end;
   } line_event_type;

endpackage

`default_nettype wire

FILE: hw/rtl/pbs_if.sv
// ----------------------------------------------------------------------------
// pbs interfaces
// Valid/ready channels for pixel requests, band results and the budget
// register write port.
// ----------------------------------------------------------------------------
`default_nettype none

interface pbs_req_if;
   logic valid;
   logic ready;
   logic pixel_on;
   logic line_last;
   logic image_last;

   modport source (output valid, output pixel_on, output line_last, output image_last,
                   input ready);
   modport sink   (input valid, input pixel_on, input line_last, input image_last,
                   output ready);
endinterface

interface pbs_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [pbs_pkg::LINE_W-1:0] band_start;
   logic [pbs_pkg::LINE_W-1:0] band_end;

   modport source (output valid, output band_start, output band_end, input ready);
   modport sink   (input valid, input band_start, input band_end, output ready);
endinterface

interface pbs_csr_if;
   logic                        valid;
   logic                        ready;
   logic [pbs_pkg::BUDGET_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/pbs_front.sv
// ----------------------------------------------------------------------------
// pbs_front
// Takes pixel requests, ORs the pixels of a line together and emits one
// line event per line end into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pbs_front (
   input  wire logic                    clock,
   input  wire logic                    reset,
   pbs_req_if.sink                      req,
   output pbs_pkg::line_event_type      ev_data,
   output logic                         ev_valid,
   input  wire logic                    ev_ready
);

   logic has_pixel_ff;
   logic has_pixel_in;
   logic accept;

   assign req.ready = ev_ready;
   assign accept    = req.valid && ev_ready;

   assign ev_valid          = req.valid && req.line_last;
   assign ev_data.filled    = has_pixel_ff || req.pixel_on;
   assign ev_data.image_end = req.image_last;

   always_comb begin
      has_pixel_in = has_pixel_ff;
      if (accept) begin
         if (req.line_last) begin
            has_pixel_in = 1'b0;
         end else begin
            has_pixel_in = has_pixel_ff || req.pixel_on;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         has_pixel_ff <= 1'b0;
      end else begin
         has_pixel_ff <= has_pixel_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/pbs_queue.sv
// ----------------------------------------------------------------------------
// pbs_queue
// Short FIFO of line events between the front end and the band logic.
// ----------------------------------------------------------------------------
`default_nettype none

module pbs_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  pbs_pkg::line_event_type      push_data,
   input  wire logic                    push_valid,
   output logic                         push_ready,
   output pbs_pkg::line_event_type      pop_data,
   output logic                         pop_valid,
   input  wire logic                    pop_ready
);

   localparam int Depth = pbs_pkg::QUEUE_DEPTH;
   localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW  = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] CntFull = CntW'(Depth);

   pbs_pkg::line_event_type entry_ff [Depth];

   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            push, pop;

   assign push_ready = (count_ff != CntFull);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntFull)
      else $error("queue count above depth");

   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == CntFull) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

FILE: hw/rtl/pbs_back.sv
// ----------------------------------------------------------------------------
// pbs_back
// Band rule: takes line events, tracks the open band and its gap budget,
// and registers closed bands onto the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module pbs_back #(
   parameter int MAX_LINES = pbs_pkg::MAX_LINES_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  pbs_pkg::line_event_type      ev_data,
   input  wire logic                    ev_valid,
   output logic                         ev_ready,
   pbs_csr_if.sink                      csr,
   pbs_rsp_if.source                    rsp
);

   localparam int LineW     = pbs_pkg::LINE_W;
   localparam int BudgetW   = pbs_pkg::BUDGET_W;
   localparam int LimitInt  = (MAX_LINES - 1 < pbs_pkg::LINE_IDX_MAX) ?
                              (MAX_LINES - 1) : pbs_pkg::LINE_IDX_MAX;
   localparam logic [LineW-1:0] LineLimit = LineW'(LimitInt);

   logic [BudgetW-1:0] budget_ff, budget_in;
   logic [LineW-1:0]   line_idx_ff, line_idx_in;
   logic               band_open_ff, band_open_in;
   logic [LineW-1:0]   start_ff, start_in;
   logic [LineW-1:0]   end_ff, end_in;
   logic [BudgetW-1:0] gap_ff, gap_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [LineW-1:0]   rsp_start_ff, rsp_start_in;
   logic [LineW-1:0]   rsp_end_ff, rsp_end_in;

   logic pop, opening, open_now, close;
   logic [BudgetW-1:0] gap_next;
   logic [LineW-1:0]   start_next, end_next;

   assign csr.ready = 1'b1;
   assign budget_in = csr.valid ? csr.data : budget_ff;

   assign ev_ready = !rsp_valid_ff || rsp.ready;
   assign pop      = ev_valid && ev_ready;

   assign opening  = ev_data.filled && !band_open_ff;
   assign open_now = band_open_ff || ev_data.filled;

   always_comb begin
      gap_next = gap_ff;
      if (opening) begin
         gap_next = budget_ff;
      end else if (band_open_ff && !ev_data.filled && gap_ff != '0) begin
         gap_next = gap_ff - 1'b1;
      end
   end

   assign start_next = opening ? line_idx_ff : start_ff;
   assign end_next   = ev_data.filled ? line_idx_ff : end_ff;
   assign close      = open_now &&
                       ((gap_next == '0 && !ev_data.filled) || ev_data.image_end);

   always_comb begin
      line_idx_in  = line_idx_ff;
      band_open_in = band_open_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      gap_in       = gap_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_start_in = rsp_start_ff;
      rsp_end_in   = rsp_end_ff;
      if (pop) begin
         band_open_in = open_now && !close;
         start_in     = start_next;
         end_in       = end_next;
         gap_in       = gap_next;
         if (ev_data.image_end) begin
            line_idx_in = '0;
         end else if (line_idx_ff < LineLimit) begin
            line_idx_in = line_idx_ff + 1'b1;
         end
         if (close) begin
            rsp_valid_in = 1'b1;
            rsp_start_in = start_next;
            rsp_end_in   = end_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff    <= pbs_pkg::GAP_BUDGET_RESET;
         line_idx_ff  <= '0;
         band_open_ff <= 1'b0;
         start_ff     <= '0;
         end_ff       <= '0;
         gap_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         budget_ff    <= budget_in;
         line_idx_ff  <= line_idx_in;
         band_open_ff <= band_open_in;
         start_ff     <= start_in;
         end_ff       <= end_in;
         gap_ff       <= gap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_start_ff <= rsp_start_in;
      rsp_end_ff   <= rsp_end_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.band_start = rsp_start_ff;
   assign rsp.band_end   = rsp_end_ff;

   a_line_limit: assert property (@(posedge clock) disable iff (reset)
      line_idx_ff <= LineLimit)
      else $error("line index past its limit");

   a_close_shuts: assert property (@(posedge clock) disable iff (reset)
      (pop && close) |=> !band_open_ff && rsp_valid_ff)
      else $error("band still open after a result");

   a_order: assert property (@(posedge clock) disable iff (reset)
      (pop && close && !ev_data.image_end) |-> rsp_start_in <= rsp_end_in)
      else $error("band start after band end");

   a_image_reset: assert property (@(posedge clock) disable iff (reset)
      (pop && ev_data.image_end) |=> line_idx_ff == '0 && !band_open_ff)
      else $error("state not cleared at image end");

endmodule

`default_nettype wire

FILE: hw/rtl/projection_band_segmentation.sv
// ----------------------------------------------------------------------------
// projection_band_segmentation
// Finds horizontal bands of non-empty lines in a streamed binary image and
// reports each band's first and last line.
// ----------------------------------------------------------------------------
//   channel   dir   payload                               handshake
//   req_ch    in    pixel_on, line_last, image_last       valid/ready
//   rsp_ch    out   band_start[11:0], band_end[11:0]      valid/ready
//   csr_ch    in    data[7:0] (gap budget, reset 16)      valid/ready, ready tied high
//
// one pixel per cycle while the line event queue has room; a band result
// follows its closing line-end pixel (front end, two-entry line event queue, band logic).
// reset is synchronous and clears all control state and the budget to 16.
// a stalled result only stops the band logic; the queue lets pixels flow
// until it holds two pending line ends.
// ----------------------------------------------------------------------------
`default_nettype none

module projection_band_segmentation #(
   parameter int MAX_LINES = pbs_pkg::MAX_LINES_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   pbs_req_if.sink   req_ch,
   pbs_rsp_if.source rsp_ch,
   pbs_csr_if.sink   csr_ch
);

   pbs_pkg::line_event_type push_data, pop_data;
   logic push_valid, push_ready, pop_valid, pop_ready;

   pbs_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_ch),
      .ev_data  (push_data),
      .ev_valid (push_valid),
      .ev_ready (push_ready)
   );

   pbs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_data  (push_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .pop_data   (pop_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready)
   );

   pbs_back #(
      .MAX_LINES (MAX_LINES)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .ev_data  (pop_data),
      .ev_valid (pop_valid),
      .ev_ready (pop_ready),
      .csr      (csr_ch),
      .rsp      (rsp_ch)
   );

endmodule

`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for projection_band_segmentation. It streams binary
// images through the pixel request channel and mirrors the band rule in a
// local line model. Each band that comes back is compared against the model.
// The gap budget is swept over both extremes and several values in between.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_LINES  = pbs_pkg::MAX_LINES_DEF;
   localparam int LINE_LIMIT = (MAX_LINES - 1 < pbs_pkg::LINE_IDX_MAX) ?
                               MAX_LINES - 1 : pbs_pkg::LINE_IDX_MAX;
   localparam int SETTLE     = 10;
   localparam int HOLD_OFF   = 400;

   typedef struct packed {
      logic pixel_on;
      logic line_last;
      logic image_last;
   } pixel_type;

   typedef struct packed {
      logic [pbs_pkg::LINE_W-1:0] start_line;
      logic [pbs_pkg::LINE_W-1:0] end_line;
   } band_type;

   logic clock;
   logic reset = 1'b1;

   pbs_req_if req_ch ();
   pbs_rsp_if rsp_ch ();
   pbs_csr_if csr_ch ();

   projection_band_segmentation #(.MAX_LINES(MAX_LINES)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   pixel_type pixels_due[$];
   band_type  bands_due[$];

   // line model state
   logic                         line_has_pixel;
   logic [pbs_pkg::LINE_W-1:0]   line_idx;
   logic                         band_is_open;
   logic [pbs_pkg::LINE_W-1:0]   band_first;
   logic [pbs_pkg::LINE_W-1:0]   band_last;
   logic [pbs_pkg::BUDGET_W-1:0] gaps_left;
   logic [pbs_pkg::BUDGET_W-1:0] gap_budget;

   int  err_count     = 0;
   int  pixels_taken  = 0;
   int  bands_checked = 0;
   int  budgets_used  = 0;
   bit  calm          = 1'b0;
   int  stall_asks    = 0;
   int  stall_done    = 0;
   int  stall_left    = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // band rule applied to one accepted pixel
   task automatic segment_pixel(input logic pix, input logic eol, input logic eoi);
      logic filled;
      band_type b;
      if (!eol) begin
         line_has_pixel = line_has_pixel | pix;
      end else begin
         filled = line_has_pixel | pix;
         if (filled) begin
            if (!band_is_open) begin
               band_is_open = 1'b1;
               band_first   = line_idx;
               gaps_left    = gap_budget;
            end
            band_last = line_idx;
         end
         if (band_is_open && gaps_left != 0 && !filled)
            gaps_left = gaps_left - 1'b1;
         if (band_is_open && ((gaps_left == 0 && !filled) || eoi)) begin
            b.start_line = band_first;
            b.end_line   = band_last;
            bands_due = {bands_due, b};
            band_is_open = 1'b0;
         end
         line_has_pixel = 1'b0;
         if (eoi)
            line_idx = '0;
         else if (line_idx < LINE_LIMIT)
            line_idx = line_idx + 1'b1;
      end
   endtask

   // pixel request driver
   always @(posedge clock) begin : drive_pixels
      pixel_type px;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            segment_pixel(req_ch.pixel_on, req_ch.line_last, req_ch.image_last);
            pixels_taken++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pixels_due.size() > 0 && (calm || $urandom_range(99) >= 6)) begin
               px = pixels_due.pop_front();
               req_ch.valid      <= 1'b1;
               req_ch.pixel_on   <= px.pixel_on;
               req_ch.line_last  <= px.line_last;
               req_ch.image_last <= px.image_last;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // band result monitor and checker
   always @(posedge clock) begin : watch_bands
      band_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (bands_due.size() == 0) begin
               $error("band (%0d, %0d) with none pending", rsp_ch.band_start, rsp_ch.band_end);
               err_count++;
            end else begin
               want = bands_due.pop_front();
               bands_checked++;
               if (rsp_ch.band_start !== want.start_line) begin
                  $error("band_start: expected %0d, got %0d", want.start_line,
                         rsp_ch.band_start);
                  err_count++;
               end
               if (rsp_ch.band_end !== want.end_line) begin
                  $error("band_end: expected %0d, got %0d", want.end_line, rsp_ch.band_end);
                  err_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (stall_done < stall_asks) begin
            // long hold-off so the line event queue backs up into the pixel input
            stall_done++;
            stall_left = HOLD_OFF;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= calm || $urandom_range(99) >= 6;
         end
      end
   end

   task automatic push_px(input logic pix, input logic eol, input logic eoi);
      pixel_type px;
      px.pixel_on   = pix;
      px.line_last  = eol;
      px.image_last = eoi;
      pixels_due = {pixels_due, px};
   endtask

   // one line of len pixels; a filled line gets at least one set pixel
   task automatic push_line(input int len, input bit filled, input bit eoi);
      int hot;
      hot = $urandom_range(len - 1, 0);
      for (int i = 0; i < len; i++)
         push_px(filled && (i == hot || $urandom_range(99) < 30), i == len - 1, eoi);
   endtask

   task automatic push_image(input logic [pbs_pkg::BUDGET_W-1:0] budget);
      int nlines;
      int len;
      int empty_run;
      int cap;
      empty_run = 0;
      nlines = $urandom_range(24, 1);
      cap = (budget < 10) ? budget + 2 : 12;
      for (int li = 0; li < nlines; li++) begin
         // stray pixel with random marks
         if ($urandom_range(99) < 5)
            push_px(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
                    1'($urandom_range(1, 0)));
         if (empty_run == 0 && $urandom_range(99) < 35)
            empty_run = $urandom_range(cap, 1);
         len = ($urandom_range(99) < 80) ? $urandom_range(4, 1) : $urandom_range(16, 5);
         push_line(len, empty_run == 0, li == nlines - 1);
         if (empty_run > 0)
            empty_run--;
      end
   endtask

   task automatic drain();
      while (pixels_due.size() > 0 || req_ch.valid || bands_due.size() > 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_budget(input logic [pbs_pkg::BUDGET_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= value;
      do
         @(posedge clock);
      while (!csr_ch.ready);
      gap_budget = value;
      budgets_used++;
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_phase(input logic [pbs_pkg::BUDGET_W-1:0] budget, input int target,
                               input bit quiet, input bit squeeze);
      int start_size;
      drain();
      write_budget(budget);
      calm = quiet;
      if (squeeze)
         stall_asks++;
      start_size = pixels_due.size();
      while (pixels_due.size() - start_size < target)
         push_image(budget);
      drain();
      calm = 1'b0;
   endtask

   initial begin
      req_ch.valid      = 1'b0;
      req_ch.pixel_on   = 1'b0;
      req_ch.line_last  = 1'b0;
      req_ch.image_last = 1'b0;
      rsp_ch.ready      = 1'b0;
      csr_ch.valid      = 1'b0;
      csr_ch.data       = '0;
      line_has_pixel    = 1'b0;
      line_idx          = '0;
      band_is_open      = 1'b0;
      band_first        = '0;
      band_last         = '0;
      gaps_left         = '0;
      gap_budget        = pbs_pkg::GAP_BUDGET_RESET;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset budget: single-pixel image, stray image mark, gap inside band
      push_px(1'b1, 1'b1, 1'b1);
      push_px(1'b0, 1'b0, 1'b1);
      push_px(1'b1, 1'b1, 1'b0);
      push_px(1'b0, 1'b1, 1'b0);
      push_px(1'b0, 1'b0, 1'b0);
      push_px(1'b1, 1'b1, 1'b1);
      push_px(1'b0, 1'b1, 1'b1);
      push_px(1'b1, 1'b0, 1'b0);
      push_px(1'b0, 1'b1, 1'b1);
      drain();

      // zero budget closes on the first empty line
      write_budget(8'd0);
      push_px(1'b1, 1'b1, 1'b0);
      push_px(1'b0, 1'b1, 1'b0);
      push_px(1'b1, 1'b1, 1'b0);
      push_px(1'b1, 1'b1, 1'b0);
      push_px(1'b0, 1'b1, 1'b1);
      drain();

      // full budget is spent across a refilled line, not reloaded
      write_budget(8'hff);
      push_px(1'b1, 1'b1, 1'b0);
      repeat (254) push_px(1'b0, 1'b1, 1'b0);
      push_px(1'b1, 1'b1, 1'b0);
      push_px(1'b0, 1'b1, 1'b0);
      push_px(1'b0, 1'b1, 1'b1);
      drain();

      random_phase(8'd1, 230, 1'b0, 1'b0);
      random_phase(8'd4, 230, 1'b0, 1'b1);
      random_phase(8'd0, 230, 1'b1, 1'b0);
      random_phase(8'($urandom_range(255, 0)), 230, 1'b0, 1'b0);
      random_phase(8'd16, 230, 1'b0, 1'b0);
      random_phase(8'd2, 230, 1'b0, 1'b0);
      random_phase(8'hff, 230, 1'b0, 1'b0);

      drain();
      $display("covered %0d pixels and %0d bands across %0d budget writes,", pixels_taken,
               bands_checked, budgets_used);
      $display("including zero and full budgets and a long result hold-off");
      if (err_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
